>>> rtl/vtcv_pkg.sv
// shared constants, types and helpers of the vertex transform, clip and viewport block
package vtcv_pkg;

  localparam int COEF_FRAC_BITS  = 10;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 32;
  localparam int COEF_W          = 16;
  localparam int ROW_W           = 4 * COEF_W;
  localparam int PROD_W          = COORD_W + COEF_W;
  localparam int ACC_W           = PROD_W + 2;
  localparam int NUM_W           = COORD_W + COORD_FRAC_BITS;
  localparam int RATIO_LIM_BIT   = 40;
  localparam int RATIO_W         = RATIO_LIM_BIT + 2;
  localparam int SCALE_W         = RATIO_W + 1;
  localparam int DIM_W           = 13;
  localparam int PIX_W           = SCALE_W + DIM_W + 1;
  localparam int SAT_IN_W        = PIX_W;
  localparam int CODE_W          = 6;
  localparam int APB_DW          = 64;
  localparam int APB_AW          = 6;
  localparam int TDATA_IN_W      = 4 * COORD_W;
  localparam int TDATA_OUT_W     = 104;

  // register indexes
  localparam logic [2:0] REG_ROW_0  = 3'd0;
  localparam logic [2:0] REG_ROW_1  = 3'd1;
  localparam logic [2:0] REG_ROW_2  = 3'd2;
  localparam logic [2:0] REG_ROW_3  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // outcode bit positions
  localparam int OC_Z_NEG = 0;
  localparam int OC_Z_W   = 1;
  localparam int OC_X_NEG = 2;
  localparam int OC_X_POS = 3;
  localparam int OC_Y_NEG = 4;
  localparam int OC_Y_POS = 5;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] n_mag;
    logic [COORD_W-1:0]      w_mag;
    logic [2:0]              n_neg;
    logic [2:0]              n_zero;
    logic                    w_neg;
    logic                    w_zero;
    logic [CODE_W-1:0]       code;
  } clip_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] quot;
    logic [2:0]            n_neg;
    logic [2:0]            n_zero;
    logic                  w_neg;
    logic                  w_zero;
    logic [CODE_W-1:0]     code;
  } div_out_t;

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(2147483647);
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN = ~SAT_MAX;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/vtcv_mat.sv
// matrix product, clip-space saturation and outcode, four register stages
module vtcv_mat (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [3:0][vtcv_pkg::COORD_W-1:0]      vtx_i,
  input  logic [3:0][vtcv_pkg::ROW_W-1:0]        matrix_i,
  output logic                                   valid_o,
  output vtcv_pkg::clip_t                        clip_o
);
  import vtcv_pkg::*;

  logic signed [PROD_W-1:0]  prod_d [4][4];
  logic signed [PROD_W-1:0]  prod_q [4][4];
  logic signed [ACC_W-1:0]   acc_d [4];
  logic signed [ACC_W-1:0]   acc_q [4];
  logic signed [COORD_W-1:0] clip_d [4];
  logic signed [COORD_W-1:0] clip_q [4];
  clip_t                     out_d;
  clip_t                     out_q;
  logic                      v1_q, v2_q, v3_q, v4_q;

  // stage 1: sixteen products
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[r][c] = $signed(vtx_i[r]) * $signed(matrix_i[r][COEF_W*c +: COEF_W]);
      end
    end
  end

  // stage 2: column sums
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_d[c] = ACC_W'(prod_q[0][c]) + ACC_W'(prod_q[1][c])
               + ACC_W'(prod_q[2][c]) + ACC_W'(prod_q[3][c]);
    end
  end

  // stage 3: fraction drop and saturation
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      clip_d[c] = sat32(SAT_IN_W'(acc_q[c] >>> COEF_FRAC_BITS));
    end
  end

  // stage 4: outcode and operand magnitudes for the divider
  always_comb begin
    logic signed [COORD_W:0] xe, ye, ze, we, nwe;
    xe  = (COORD_W+1)'(clip_q[0]);
    ye  = (COORD_W+1)'(clip_q[1]);
    ze  = (COORD_W+1)'(clip_q[2]);
    we  = (COORD_W+1)'(clip_q[3]);
    nwe = -we;
    out_d.code           = '0;
    out_d.code[OC_Z_NEG] = ze < 0;
    out_d.code[OC_Z_W]   = ze > we;
    out_d.code[OC_X_NEG] = xe < nwe;
    out_d.code[OC_X_POS] = xe > we;
    out_d.code[OC_Y_NEG] = ye < nwe;
    out_d.code[OC_Y_POS] = ye > we;
    for (int l = 0; l < 3; l++) begin
      out_d.n_neg[l]  = clip_q[l][COORD_W-1];
      out_d.n_zero[l] = clip_q[l] == '0;
      out_d.n_mag[l]  = clip_q[l][COORD_W-1] ? (~clip_q[l] + 1'b1) : clip_q[l];
    end
    out_d.w_neg  = clip_q[3][COORD_W-1];
    out_d.w_zero = clip_q[3] == '0;
    out_d.w_mag  = clip_q[3][COORD_W-1] ? (~clip_q[3] + 1'b1) : clip_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      clip_q <= clip_d;
      out_q  <= out_d;
    end
  end

  assign valid_o = v4_q;
  assign clip_o  = out_q;

endmodule

>>> rtl/vtcv_div.sv
// three-lane restoring divider, one quotient bit per register stage
module vtcv_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vtcv_pkg::clip_t    clip_i,
  output logic               valid_o,
  output vtcv_pkg::div_out_t res_o
);
  import vtcv_pkg::*;

  localparam int STEPS = NUM_W;

  typedef struct packed {
    logic [2:0]        n_neg;
    logic [2:0]        n_zero;
    logic              w_neg;
    logic              w_zero;
    logic [CODE_W-1:0] code;
  } side_t;

  logic                vld  [STEPS+1];
  logic [NUM_W-1:0]    num  [STEPS+1][3];
  logic [COORD_W-1:0]  rem  [STEPS+1][3];
  logic [NUM_W-1:0]    quo  [STEPS+1][3];
  logic [COORD_W-1:0]  dvs  [STEPS+1];
  side_t               side [STEPS+1];

  assign vld[0]         = valid_i;
  assign dvs[0]         = clip_i.w_mag;
  assign side[0].n_neg  = clip_i.n_neg;
  assign side[0].n_zero = clip_i.n_zero;
  assign side[0].w_neg  = clip_i.w_neg;
  assign side[0].w_zero = clip_i.w_zero;
  assign side[0].code   = clip_i.code;

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign num[0][l] = {clip_i.n_mag[l], {COORD_FRAC_BITS{1'b0}}};
    assign rem[0][l] = '0;
    assign quo[0][l] = '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs[k+1]  <= dvs[k];
        side[k+1] <= side[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [COORD_W:0] trial;
      logic             fits;
      assign trial = {rem[k][l], num[k][l][NUM_W-1]};
      assign fits  = trial >= {1'b0, dvs[k]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num[k+1][l] <= {num[k][l][NUM_W-2:0], 1'b0};
          rem[k+1][l] <= fits ? COORD_W'(trial - {1'b0, dvs[k]}) : trial[COORD_W-1:0];
          quo[k+1][l] <= {quo[k][l][NUM_W-2:0], fits};
        end
      end
    end
  end

  assign valid_o      = vld[STEPS];
  assign res_o.n_neg  = side[STEPS].n_neg;
  assign res_o.n_zero = side[STEPS].n_zero;
  assign res_o.w_neg  = side[STEPS].w_neg;
  assign res_o.w_zero = side[STEPS].w_zero;
  assign res_o.code   = side[STEPS].code;
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign res_o.quot[l] = quo[STEPS][l];
  end

endmodule

>>> rtl/vtcv_view.sv
// ratio clamp, viewport scale and output saturation, four register stages
module vtcv_view (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  vtcv_pkg::div_out_t               div_i,
  input  logic [vtcv_pkg::DIM_W-1:0]       width_i,
  input  logic [vtcv_pkg::DIM_W-1:0]       height_i,
  output logic                             valid_o,
  output logic [vtcv_pkg::CODE_W-1:0]      code_o,
  output logic signed [vtcv_pkg::COORD_W-1:0] sx_o,
  output logic signed [vtcv_pkg::COORD_W-1:0] sy_o,
  output logic signed [vtcv_pkg::COORD_W-1:0] depth_o,
  output logic                             wz_o
);
  import vtcv_pkg::*;

  localparam logic [RATIO_W-2:0]          LIM = (RATIO_W-1)'(1) << RATIO_LIM_BIT;
  localparam logic signed [SCALE_W-1:0]   ONE = SCALE_W'(1) << COORD_FRAC_BITS;

  logic signed [RATIO_W-1:0] ratio_d [3];
  logic signed [RATIO_W-1:0] ratio_q [3];
  logic signed [SCALE_W-1:0] ax_d, ay_d, ax_q, ay_q;
  logic signed [COORD_W-1:0] dz_d, dz_q, dz2_q;
  logic signed [PIX_W-1:0]   px_d, py_d, px_q, py_q;
  logic signed [COORD_W-1:0] sx_d, sy_d, sx_q, sy_q, dz3_q;
  logic [CODE_W-1:0]         code_a_q, code_b_q, code_c_q, code_d_q;
  logic                      wz_a_q, wz_b_q, wz_c_q, wz_d_q;
  logic                      va_q, vb_q, vc_q, vd_q;

  // stage a: signed, clamped ratios
  always_comb begin
    logic [RATIO_W-2:0] mag;
    for (int l = 0; l < 3; l++) begin
      mag = (div_i.quot[l] > NUM_W'(LIM)) ? LIM : div_i.quot[l][RATIO_W-2:0];
      if (div_i.w_zero) begin
        mag = div_i.n_zero[l] ? '0 : LIM;
        ratio_d[l] = div_i.n_neg[l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end else begin
        ratio_d[l] = (div_i.n_neg[l] ^ div_i.w_neg) ? -$signed({1'b0, mag})
                                                    : $signed({1'b0, mag});
      end
    end
  end

  // stage b: offset by one
  assign ax_d = SCALE_W'(ratio_q[0]) + ONE;
  assign ay_d = ONE - SCALE_W'(ratio_q[1]);
  assign dz_d = sat32(SAT_IN_W'(ratio_q[2]));

  // stage c: scale by the viewport size
  assign px_d = ax_q * $signed({1'b0, width_i});
  assign py_d = ay_q * $signed({1'b0, height_i});

  // stage d: halve and saturate
  assign sx_d = sat32(px_q >>> 1);
  assign sy_d = sat32(py_q >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ratio_q  <= ratio_d;
      code_a_q <= div_i.code;
      wz_a_q   <= div_i.w_zero;
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      dz_q     <= dz_d;
      code_b_q <= code_a_q;
      wz_b_q   <= wz_a_q;
      px_q     <= px_d;
      py_q     <= py_d;
      dz2_q    <= dz_q;
      code_c_q <= code_b_q;
      wz_c_q   <= wz_b_q;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      dz3_q    <= dz2_q;
      code_d_q <= code_c_q;
      wz_d_q   <= wz_c_q;
    end
  end

  assign valid_o = vd_q;
  assign code_o  = code_d_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign depth_o = dz3_q;
  assign wz_o    = wz_d_q;

endmodule

>>> rtl/vertex_transform_clip_viewport_top.sv
// top level: register file, pipeline hookup and stream ports
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    x, y, z, w
// m_axis    out  m_axis_tvalid/m_axis_tready    outcode, screen x, y, depth; tuser w zero
// apb       in   psel/penable/pready            matrix rows, width, height
//
// one vertex per cycle while the output is not stalled; 4 matrix stages, 48 divider steps, 4 viewport stages
// the divider retires one quotient bit per stage for all three lanes
// reset clears valid bits and loads identity matrix, 640 by 480 viewport
// a stalled output holds the whole pipeline, nothing is dropped or repeated
module vertex_transform_clip_viewport_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x [31:0], y [63:32], z [95:64], w [127:96]
  input  logic [vtcv_pkg::TDATA_IN_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // outcode [5:0], screen x [37:6], screen y [69:38], depth [101:70], zero [103:102]
  output logic [vtcv_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
  // w is zero [0]
  output logic                                  m_axis_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vtcv_pkg::APB_AW-1:0]           paddr,
  input  logic [vtcv_pkg::APB_DW-1:0]           pwdata,
  output logic [vtcv_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);
  import vtcv_pkg::*;

  logic [3:0][ROW_W-1:0]    matrix_q;
  logic [DIM_W-1:0]         width_q;
  logic [DIM_W-1:0]         height_q;
  logic [2:0]               reg_idx;
  logic                     wr_en;
  logic                     en;
  logic [3:0][COORD_W-1:0]  vtx;
  logic                     mat_valid, div_valid, out_valid;
  clip_t                    clip;
  div_out_t                 div_res;
  logic [CODE_W-1:0]        code;
  logic signed [COORD_W-1:0] sx, sy, dz;
  logic                     wz;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        matrix_q[r] <= ROW_W'(1 << COEF_FRAC_BITS) << (COEF_W * r);
      end
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROW_0:  matrix_q[0] <= pwdata;
        REG_ROW_1:  matrix_q[1] <= pwdata;
        REG_ROW_2:  matrix_q[2] <= pwdata;
        REG_ROW_3:  matrix_q[3] <= pwdata;
        REG_WIDTH:  width_q     <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_0:  prdata = matrix_q[0];
      REG_ROW_1:  prdata = matrix_q[1];
      REG_ROW_2:  prdata = matrix_q[2];
      REG_ROW_3:  prdata = matrix_q[3];
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline advances when the output register is free or being emptied
  assign en            = ~out_valid | m_axis_tready;
  assign s_axis_tready = en;

  for (genvar r = 0; r < 4; r++) begin : g_vtx
    assign vtx[r] = s_axis_tdata[COORD_W*r +: COORD_W];
  end

  vtcv_mat u_mat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .vtx_i    (vtx),
    .matrix_i (matrix_q),
    .valid_o  (mat_valid),
    .clip_o   (clip)
  );

  vtcv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .clip_i  (clip),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  vtcv_view u_view (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid),
    .div_i    (div_res),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (out_valid),
    .code_o   (code),
    .sx_o     (sx),
    .sy_o     (sy),
    .depth_o  (dz),
    .wz_o     (wz)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, dz, sy, sx, code};
  assign m_axis_tuser  = wz;

endmodule

>>> rtl/vtcv_checker.sv
// port-level checker for the vertex transform, clip and viewport block, with its bind
module vtcv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // a pending transfer stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // an empty output never blocks the input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // zero w: depth saturates to the sign of z, as the outcode shows
  a_wz_depth_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      ((m_axis_tdata[101:70] == 32'h7fffffff) == m_axis_tdata[1]))
    else $error("zero w depth does not match z above w");

  a_wz_depth_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      ((m_axis_tdata[101:70] == 32'h80000000) == m_axis_tdata[0]))
    else $error("zero w depth does not match z below zero");

endmodule

bind vertex_transform_clip_viewport_top vtcv_checker u_vtcv_checker (.*);
